/* src/dual_motor_spi_pwm_controller_defines.svh */
// Assertion macros shared by the RTL of the dual motor controller.
// Every macro samples on the rising edge of clk and is quiet while arst_n is low.
`ifndef DUAL_MOTOR_SPI_PWM_CONTROLLER_DEFINES_SVH
`define DUAL_MOTOR_SPI_PWM_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMSPC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never be true.
`define DMSPC_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* src/dmspc_pkg.sv */
`default_nettype none

package dmspc_pkg;

	// Kind of input transfer.
	localparam logic CMD_EXCHANGE = 1'b0;
	localparam logic CMD_TICK     = 1'b1;

	// Bytes seen on the SPI side.
	localparam logic [7:0] CMD_SPEED = 8'h56;
	localparam logic [7:0] TX_IDLE   = 8'h01;
	localparam logic [7:0] TX_NONE   = 8'h00;

	// Position of the four speed bytes inside one 'V' command.
	localparam logic [1:0] IDX_ONE_HIGH = 2'd0;
	localparam logic [1:0] IDX_ONE_LOW  = 2'd1;
	localparam logic [1:0] IDX_TWO_HIGH = 2'd2;
	localparam logic [1:0] IDX_TWO_LOW  = 2'd3;

	typedef enum logic [1:0] {
		DIR_STOP    = 2'd0,
		DIR_FORWARD = 2'd1,
		DIR_REVERSE = 2'd2
	} dir_t;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
		logic       fault;
	} item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       m1_forward_pin;
		logic       m1_reverse_pin;
		logic       m2_forward_pin;
		logic       m2_reverse_pin;
		logic       status_led;
		logic       speeds_updated;
	} result_t;

endpackage

`default_nettype wire

/* src/dual_motor_spi_pwm_controller.sv */
// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  dmspc_pkg::item_t (command, rx_byte, fault)
// result    out        result_valid/...stall  dmspc_pkg::result_t (tx_byte, pins, led, flag)
//
// One transfer in gives exactly one transfer out. A new item is taken every cycle unless
// item_stall is high: the input register feeds the result register, and the
// whole step (speed decode, PWM counter compare, pin update) sits between the two.
// Reset (arst_n low) clears the decoder to idle, speeds to stop, the counter and all pins.
// A stall on result holds the result register; the input register then fills and item_stall
// rises in the same cycle, so no more than two items are ever in flight.
`default_nettype none

`include "dual_motor_spi_pwm_controller_defines.svh"

module dual_motor_spi_pwm_controller #(
	parameter int PWM_BITS = 12
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic item_valid,
	output                     logic item_stall,
	input  dmspc_pkg::item_t   item,
	output                     logic result_valid,
	input  wire                logic result_stall,
	output dmspc_pkg::result_t result
);

	// Largest duty the counter can express, held at the width of a raw speed.
	localparam logic [15:0] MaxDuty = 16'((32'd1 << PWM_BITS) - 32'd1);

	typedef enum logic {
		ST_IDLE,
		ST_COLLECT
	} state_t;

	// Input register.
	logic                valid_s1;
	dmspc_pkg::item_t    item_s1;

	// Block state.
	state_t              state_q;
	logic [1:0]          byte_index_q;
	logic [15:0]         speed_one_q;
	logic [7:0]          speed_two_high_q;
	dmspc_pkg::dir_t     dir_one_q;
	dmspc_pkg::dir_t     dir_two_q;
	logic [PWM_BITS-1:0] duty_one_q;
	logic [PWM_BITS-1:0] duty_two_q;
	logic [PWM_BITS-1:0] counter_q;
	logic [3:0]          pins_q;

	// Result register.
	logic                result_valid_q;
	dmspc_pkg::result_t  result_q;

	// Next values of the step.
	state_t              state_nx;
	logic [1:0]          byte_index_nx;
	logic [15:0]         speed_one_nx;
	logic [7:0]          speed_two_high_nx;
	dmspc_pkg::dir_t     dir_one_nx;
	dmspc_pkg::dir_t     dir_two_nx;
	logic [PWM_BITS-1:0] duty_one_nx;
	logic [PWM_BITS-1:0] duty_two_nx;
	logic [PWM_BITS-1:0] counter_nx;
	logic [3:0]          pins_nx;
	logic [7:0]          tx_nx;
	logic                updated_nx;

	logic                dir_one_run;
	logic                dir_two_run;
	dmspc_pkg::dir_t     dir_one_new;
	dmspc_pkg::dir_t     dir_two_new;
	logic [PWM_BITS-1:0] duty_one_new;
	logic [PWM_BITS-1:0] duty_two_new;
	logic [15:0]         speed_two_raw;

	logic                advance;
	logic                take;

	// The result register can load when it is empty or its content leaves now.
	assign advance = !result_valid_q || !result_stall;
	// The input register can load when it is empty or its item moves on.
	assign item_stall = valid_s1 && !advance;
	assign take = item_valid && !item_stall;

	assign result_valid = result_valid_q;
	assign result = result_q;

	// Sign and magnitude of a raw speed, the magnitude saturated to the counter range.
	// A negated 0x8000 is still 0x8000 as an unsigned magnitude, which then saturates.
	function automatic dmspc_pkg::dir_t speed_dir(input logic [15:0] raw);
		dmspc_pkg::dir_t d;
		if (raw == 16'd0) begin
			d = dmspc_pkg::DIR_STOP;
		end else if (raw[15]) begin
			d = dmspc_pkg::DIR_REVERSE;
		end else begin
			d = dmspc_pkg::DIR_FORWARD;
		end
		return d;
	endfunction

	function automatic logic [PWM_BITS-1:0] speed_duty(input logic [15:0] raw);
		logic [15:0] mag;
		mag = raw[15] ? (16'd0 - raw) : raw;
		if (mag > MaxDuty) begin
			mag = MaxDuty;
		end
		return mag[PWM_BITS-1:0];
	endfunction

	assign speed_two_raw = {speed_two_high_q, item_s1.rx_byte};
	assign dir_one_new   = speed_dir(speed_one_q);
	assign dir_two_new   = speed_dir(speed_two_raw);
	assign duty_one_new  = speed_duty(speed_one_q);
	assign duty_two_new  = speed_duty(speed_two_raw);

	assign dir_one_run = (dir_one_q != dmspc_pkg::DIR_STOP);
	assign dir_two_run = (dir_two_q != dmspc_pkg::DIR_STOP);

	always_comb begin
		state_nx          = state_q;
		byte_index_nx     = byte_index_q;
		speed_one_nx      = speed_one_q;
		speed_two_high_nx = speed_two_high_q;
		dir_one_nx        = dir_one_q;
		dir_two_nx        = dir_two_q;
		duty_one_nx       = duty_one_q;
		duty_two_nx       = duty_two_q;
		counter_nx        = counter_q;
		pins_nx           = pins_q;
		tx_nx             = dmspc_pkg::TX_NONE;
		updated_nx        = 1'b0;

		if (item_s1.command == dmspc_pkg::CMD_TICK) begin
			counter_nx = counter_q + PWM_BITS'(1);
			// At wrap a running motor drives the pin of its direction; the other goes low.
			if (counter_nx == '0) begin
				if (dir_one_run) begin
					pins_nx[0] = (dir_one_q == dmspc_pkg::DIR_FORWARD);
					pins_nx[1] = (dir_one_q == dmspc_pkg::DIR_REVERSE);
				end
				if (dir_two_run) begin
					pins_nx[2] = (dir_two_q == dmspc_pkg::DIR_FORWARD);
					pins_nx[3] = (dir_two_q == dmspc_pkg::DIR_REVERSE);
				end
			end
			// The compare wins over the wrap when the duty is zero.
			if (counter_nx == duty_one_q) begin
				pins_nx[1:0] = 2'b00;
			end
			if (counter_nx == duty_two_q) begin
				pins_nx[3:2] = 2'b00;
			end
		end else if (!item_s1.fault) begin
			if (state_q == ST_IDLE) begin
				tx_nx         = dmspc_pkg::TX_IDLE;
				byte_index_nx = dmspc_pkg::IDX_ONE_HIGH;
				state_nx      = (item_s1.rx_byte == dmspc_pkg::CMD_SPEED) ? ST_COLLECT : ST_IDLE;
			end else begin
				tx_nx = dmspc_pkg::CMD_SPEED;
				unique case (byte_index_q)
					dmspc_pkg::IDX_ONE_HIGH: begin
						speed_one_nx  = {item_s1.rx_byte, 8'h00};
						byte_index_nx = dmspc_pkg::IDX_ONE_LOW;
					end
					dmspc_pkg::IDX_ONE_LOW: begin
						speed_one_nx  = {speed_one_q[15:8], item_s1.rx_byte};
						byte_index_nx = dmspc_pkg::IDX_TWO_HIGH;
					end
					dmspc_pkg::IDX_TWO_HIGH: begin
						speed_two_high_nx = item_s1.rx_byte;
						byte_index_nx     = dmspc_pkg::IDX_TWO_LOW;
					end
					dmspc_pkg::IDX_TWO_LOW: begin
						dir_one_nx  = dir_one_new;
						duty_one_nx = duty_one_new;
						dir_two_nx  = dir_two_new;
						duty_two_nx = duty_two_new;
						// A stopped motor releases both pins at once; a running one waits
						// for the next wrap or compare.
						if (dir_one_new == dmspc_pkg::DIR_STOP) begin
							pins_nx[1:0] = 2'b00;
						end
						if (dir_two_new == dmspc_pkg::DIR_STOP) begin
							pins_nx[3:2] = 2'b00;
						end
						byte_index_nx = dmspc_pkg::IDX_ONE_HIGH;
						state_nx      = ST_IDLE;
						updated_nx    = 1'b1;
					end
					default: begin
						byte_index_nx = dmspc_pkg::IDX_ONE_HIGH;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			item_s1          <= '0;
			state_q          <= ST_IDLE;
			byte_index_q     <= dmspc_pkg::IDX_ONE_HIGH;
			speed_one_q      <= '0;
			speed_two_high_q <= '0;
			dir_one_q        <= dmspc_pkg::DIR_STOP;
			dir_two_q        <= dmspc_pkg::DIR_STOP;
			duty_one_q       <= '0;
			duty_two_q       <= '0;
			counter_q        <= '0;
			pins_q           <= '0;
			result_valid_q   <= 1'b0;
			result_q         <= '0;
		end else begin
			if (advance) begin
				valid_s1 <= take;
			end else if (take) begin
				valid_s1 <= 1'b1;
			end
			if (take) begin
				item_s1 <= item;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
			if (advance && valid_s1) begin
				state_q          <= state_nx;
				byte_index_q     <= byte_index_nx;
				speed_one_q      <= speed_one_nx;
				speed_two_high_q <= speed_two_high_nx;
				dir_one_q        <= dir_one_nx;
				dir_two_q        <= dir_two_nx;
				duty_one_q       <= duty_one_nx;
				duty_two_q       <= duty_two_nx;
				counter_q        <= counter_nx;
				pins_q           <= pins_nx;
				result_q.tx_byte        <= tx_nx;
				result_q.m1_forward_pin <= pins_nx[0];
				result_q.m1_reverse_pin <= pins_nx[1];
				result_q.m2_forward_pin <= pins_nx[2];
				result_q.m2_reverse_pin <= pins_nx[3];
				result_q.status_led     <= !item_s1.fault;
				result_q.speeds_updated <= updated_nx;
			end
		end
	end

	// A motor never drives both of its pins.
	`DMSPC_ASSERT_NEVER(a_m1_pins_exclusive, pins_q[0] && pins_q[1], "motor one drives both pins")
	`DMSPC_ASSERT_NEVER(a_m2_pins_exclusive, pins_q[2] && pins_q[3], "motor two drives both pins")
	// A stopped motor one keeps both of its pins low.
	`DMSPC_ASSERT_IMPLY(a_stop_pins_low, dir_one_q == dmspc_pkg::DIR_STOP, pins_q[1:0] == 2'b00, "stopped motor one has a pin high")
	// A completed speed pair leaves the decoder idle.
	`DMSPC_ASSERT_IMPLY(a_update_idle, result_valid_q && result_q.speeds_updated, state_q == ST_IDLE, "decoder still collecting after a speed update")

endmodule

`default_nettype wire

/* dv/tb_dual_motor_spi_pwm_controller.sv */
module tb_dual_motor_spi_pwm_controller;
	timeunit 1ns;
	timeprecision 1ps;

	// The PWM width matches the default of the block; the duty saturates at all ones.
	localparam int PWM_W = 12;
	localparam logic [PWM_W-1:0] DUTY_MAX = '1;

	// Short names for the bytes that fill the directed table.
	localparam logic [7:0] CMD_SPEED = dmspc_pkg::CMD_SPEED;
	localparam logic [7:0] TX_IDLE   = dmspc_pkg::TX_IDLE;
	localparam logic [7:0] TX_NONE   = dmspc_pkg::TX_NONE;

	// Command letters that the block does not implement; it treats them like any other byte.
	localparam logic [7:0] CMD_P = 8'h50;
	localparam logic [7:0] CMD_S = 8'h53;
	localparam logic [7:0] CMD_R = 8'h52;

	// Generous bound on the run.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS = 355;

	// One row of the directed table. When "typed" is set, "want" is the expected
	// result written out by hand; otherwise the predictor supplies it.
	typedef struct packed {
		dmspc_pkg::item_t   stim;
		logic               typed;
		dmspc_pkg::result_t want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	dmspc_pkg::item_t   item;
	logic               result_valid;
	logic               result_stall;
	dmspc_pkg::result_t result;

	// Shadow copy of the controller state, advanced once per accepted input transfer.
	logic             spi_collecting;
	logic [1:0]       spi_index;
	logic [15:0]      speed_one_word;
	logic [7:0]       speed_two_high;
	dmspc_pkg::dir_t  dir_one;
	dmspc_pkg::dir_t  dir_two;
	logic [PWM_W-1:0] duty_one;
	logic [PWM_W-1:0] duty_two;
	logic [PWM_W-1:0] pwm_count;
	// Bit 0 is motor one forward, bit 1 motor one reverse, bit 2 motor two forward,
	// bit 3 motor two reverse.
	logic [3:0]       pin_state;

	// Results still owed by the block, oldest first.
	dmspc_pkg::result_t pending_outputs[$];

	int  mismatch_count;
	int  counted_items;
	int  cycle_count;
	bit  sender_quiet;
	row_t directed_rows [25];

	dual_motor_spi_pwm_controller DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Turns a signed 16-bit speed into a direction and a saturated duty for one motor.
	// A zero speed stops the motor and drops both of its pins right away, while a
	// nonzero speed leaves the pins alone until the next wrap or compare.
	function automatic void decode_speed(input logic [15:0] raw, input int motor);
		logic [16:0]     mag;
		dmspc_pkg::dir_t dir;
		if (raw == 16'd0) begin
			dir = dmspc_pkg::DIR_STOP;
			mag = '0;
			pin_state[2*motor +: 2] = 2'b00;
		end else if (raw[15]) begin
			// Two's complement magnitude; -32768 gives 32768 and saturates below.
			dir = dmspc_pkg::DIR_REVERSE;
			mag = 17'h10000 - {1'b0, raw};
		end else begin
			dir = dmspc_pkg::DIR_FORWARD;
			mag = {1'b0, raw};
		end
		if (mag > 17'(DUTY_MAX))
			mag = 17'(DUTY_MAX);
		if (motor == 0) begin
			dir_one = dir;
			duty_one = mag[PWM_W-1:0];
		end else begin
			dir_two = dir;
			duty_two = mag[PWM_W-1:0];
		end
	endfunction

	// At the counter wrap, a running motor raises the pin of its direction and
	// lowers the other one. A stopped motor keeps its pins as they are.
	function automatic void wrap_pins(input dmspc_pkg::dir_t dir, input int motor);
		if (dir == dmspc_pkg::DIR_FORWARD)
			pin_state[2*motor +: 2] = 2'b01;
		else if (dir == dmspc_pkg::DIR_REVERSE)
			pin_state[2*motor +: 2] = 2'b10;
	endfunction

	// Advances the shadow state by one input transfer and returns the result that
	// the block has to produce for it.
	function automatic dmspc_pkg::result_t controller_step(input dmspc_pkg::item_t it);
		dmspc_pkg::result_t r;
		r = '0;
		if (it.command == dmspc_pkg::CMD_TICK) begin
			pwm_count = pwm_count + PWM_W'(1);
			if (pwm_count == '0) begin
				wrap_pins(dir_one, 0);
				wrap_pins(dir_two, 1);
			end
			// The compare comes after the wrap, so a zero duty never shows a pulse.
			if (pwm_count == duty_one)
				pin_state[1:0] = 2'b00;
			if (pwm_count == duty_two)
				pin_state[3:2] = 2'b00;
		end else if (!it.fault) begin
			if (!spi_collecting) begin
				// Idle: answer 1, and only the speed command opens a collection.
				r.tx_byte = TX_IDLE;
				spi_index = dmspc_pkg::IDX_ONE_HIGH;
				spi_collecting = (it.rx_byte == CMD_SPEED);
			end else begin
				r.tx_byte = CMD_SPEED;
				case (spi_index)
					dmspc_pkg::IDX_ONE_HIGH: begin
						speed_one_word = {it.rx_byte, 8'h00};
						spi_index = dmspc_pkg::IDX_ONE_LOW;
					end
					dmspc_pkg::IDX_ONE_LOW: begin
						speed_one_word[7:0] = it.rx_byte;
						spi_index = dmspc_pkg::IDX_TWO_HIGH;
					end
					dmspc_pkg::IDX_TWO_HIGH: begin
						speed_two_high = it.rx_byte;
						spi_index = dmspc_pkg::IDX_TWO_LOW;
					end
					default: begin
						decode_speed(speed_one_word, 0);
						decode_speed({speed_two_high, it.rx_byte}, 1);
						spi_index = dmspc_pkg::IDX_ONE_HIGH;
						spi_collecting = 1'b0;
						r.speeds_updated = 1'b1;
					end
				endcase
			end
		end
		// An exchange under fault leaves the state alone and answers nothing.
		r.m1_forward_pin = pin_state[0];
		r.m1_reverse_pin = pin_state[1];
		r.m2_forward_pin = pin_state[2];
		r.m2_reverse_pin = pin_state[3];
		r.status_led = ~it.fault;
		return r;
	endfunction

	function automatic dmspc_pkg::item_t exchange_item(input logic [7:0] rx, input logic fault);
		dmspc_pkg::item_t it;
		it.command = dmspc_pkg::CMD_EXCHANGE;
		it.rx_byte = rx;
		it.fault = fault;
		return it;
	endfunction

	function automatic dmspc_pkg::item_t tick_item(input logic fault, input logic [7:0] rx);
		dmspc_pkg::item_t it;
		it.command = dmspc_pkg::CMD_TICK;
		it.rx_byte = rx;
		it.fault = fault;
		return it;
	endfunction

	// Expected result for the directed rows, where no pin can be high yet.
	function automatic dmspc_pkg::result_t pins_low(input logic [7:0] tx, input logic led,
			input logic updated);
		dmspc_pkg::result_t r;
		r = '0;
		r.tx_byte = tx;
		r.status_led = led;
		r.speeds_updated = updated;
		return r;
	endfunction

	// Ticks carry a random byte, which the block must ignore, and now and then a fault.
	function automatic dmspc_pkg::item_t random_tick();
		return tick_item($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
	endfunction

	// Mostly short pauses, with the occasional long one.
	function automatic int idle_length();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	// Speeds weighted toward zero, the saturation boundary and the 16-bit extremes.
	function automatic logic [15:0] random_speed();
		logic [15:0] s;
		case ($urandom_range(0, 9))
			0: s = 16'h0000;
			1: s = 16'h8000;
			2: s = 16'h7FFF;
			3: s = 16'($urandom_range(1, 4095));
			4: s = 16'h0000 - 16'($urandom_range(1, 4095));
			5: begin
				case ($urandom_range(0, 3))
					0: s = 16'h0FFF;
					1: s = 16'h1000;
					2: s = 16'hF000;
					default: s = 16'hF001;
				endcase
			end
			6: s = ($urandom_range(0, 1) == 0) ? 16'h0001 : 16'hFFFF;
			default: s = 16'($urandom_range(0, 65535));
		endcase
		return s;
	endfunction

	task automatic report_mismatch(input string what, input dmspc_pkg::result_t got,
			input dmspc_pkg::result_t want);
		$display("mismatch in %s at cycle %0d: got %p, expected %p",
			what, cycle_count, got, want);
		mismatch_count++;
	endtask

	task automatic check_result(input dmspc_pkg::result_t got);
		dmspc_pkg::result_t want;
		if (pending_outputs.size() == 0) begin
			report_mismatch("result with nothing pending", got, '0);
			return;
		end
		want = pending_outputs.pop_front();
		if (got !== want)
			report_mismatch("result", got, want);
	endtask

	// Presents one item and holds it until the transfer happens. All inputs change
	// only through nonblocking assignments at the rising edge, so the handshake
	// signals read right after the edge still hold the values that the edge used.
	// The prediction is made at the accepting edge, which keeps the expectations
	// in the order in which the block took the items.
	task automatic send_item(input dmspc_pkg::item_t it, input logic typed,
			input dmspc_pkg::result_t want);
		dmspc_pkg::result_t predicted;
		if (!sender_quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat (idle_length()) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted = controller_step(it);
		pending_outputs.push_back(typed ? want : predicted);
		counted_items++;
	endtask

	task automatic send_plain(input dmspc_pkg::item_t it);
		send_item(it, 1'b0, '0);
	endtask

	// A complete speed command with random speeds. Ticks and dropped exchanges may
	// land between the bytes, since neither of them disturbs the collection.
	task automatic send_speed_pair();
		logic [15:0] s1;
		logic [15:0] s2;
		logic [7:0]  payload [4];
		s1 = random_speed();
		s2 = random_speed();
		payload = '{s1[15:8], s1[7:0], s2[15:8], s2[7:0]};
		send_plain(exchange_item(CMD_SPEED, 1'b0));
		for (int b = 0; b < 4; b++) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 5)) send_plain(random_tick());
			if ($urandom_range(0, 19) == 0)
				send_plain(exchange_item(8'($urandom_range(0, 255)), 1'b1));
			send_plain(exchange_item(payload[b], 1'b0));
		end
	endtask

	// Stray exchanges: the idle zero, the commands that are not implemented, random
	// bytes and a lone speed command that starts a collection fed by later noise.
	task automatic send_noise();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0: b = 8'h00;
			1: b = CMD_P;
			2: b = CMD_S;
			3: b = CMD_R;
			4: b = CMD_SPEED;
			default: b = 8'($urandom_range(0, 255));
		endcase
		send_plain(exchange_item(b, $urandom_range(0, 4) == 0));
	endtask

	task automatic send_random_event();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			send_speed_pair();
		else if (pick < 80)
			repeat ($urandom_range(1, 30)) send_plain(random_tick());
		else
			send_noise();
	endtask

	// Holds the sender off until every outstanding result has come back.
	task automatic drain_results();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_outputs.size() != 0);
	endtask

	// Result side: check each transfer, then pick the stall for the next edge.
	// At each switch point the side picks afresh whether to run a stretch without stalls.
	initial begin : result_side
		int  hold;
		int  since_switch;
		bit  rx_quiet;
		hold = 0;
		since_switch = 0;
		rx_quiet = 1'b0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				check_result(result);
			since_switch++;
			if (since_switch == 256) begin
				since_switch = 0;
				rx_quiet = ($urandom_range(0, 2) == 0);
			end
			if (hold > 0) begin
				hold--;
				result_stall <= 1'b1;
			end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
				hold = idle_length() - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int phase_end;

		mismatch_count = 0;
		counted_items = 0;
		sender_quiet = 1'b0;

		spi_collecting = 1'b0;
		spi_index = dmspc_pkg::IDX_ONE_HIGH;
		speed_one_word = '0;
		speed_two_high = '0;
		dir_one = dmspc_pkg::DIR_STOP;
		dir_two = dmspc_pkg::DIR_STOP;
		duty_one = '0;
		duty_two = '0;
		pwm_count = '0;
		pin_state = '0;

		// Directed part. The counter stays far from its wrap here, so every pin is
		// low and the typed results only differ in the reply byte, the LED and the
		// update flag.
		directed_rows = '{
			// Right after reset, a tick under fault: the counter steps, the LED goes low, nothing else moves.
			'{tick_item(1'b1, 8'hA5), 1'b1, pins_low(TX_NONE, 1'b0, 1'b0)},
			// Idle command zero and an unimplemented command keep the block idle.
			'{exchange_item(8'h00, 1'b0), 1'b1, pins_low(TX_IDLE, 1'b1, 1'b0)},
			'{exchange_item(CMD_P, 1'b0), 1'b1, pins_low(TX_IDLE, 1'b1, 1'b0)},
			// An exchange under fault is dropped without a reply.
			'{exchange_item(8'hFF, 1'b1), 1'b1, pins_low(TX_NONE, 1'b0, 1'b0)},
			// Speeds -32768 and +32767, with a dropped byte inside the command.
			'{exchange_item(CMD_SPEED, 1'b0), 1'b1, pins_low(TX_IDLE, 1'b1, 1'b0)},
			'{exchange_item(8'h80, 1'b1), 1'b1, pins_low(TX_NONE, 1'b0, 1'b0)},
			'{exchange_item(8'h80, 1'b0), 1'b1, pins_low(CMD_SPEED, 1'b1, 1'b0)},
			'{exchange_item(8'h00, 1'b0), 1'b1, pins_low(CMD_SPEED, 1'b1, 1'b0)},
			'{exchange_item(8'h7F, 1'b0), 1'b1, pins_low(CMD_SPEED, 1'b1, 1'b0)},
			'{exchange_item(8'hFF, 1'b0), 1'b1, pins_low(CMD_SPEED, 1'b1, 1'b1)},
			// Zero speed for motor one and -1 for motor two.
			'{exchange_item(CMD_SPEED, 1'b0), 1'b1, pins_low(TX_IDLE, 1'b1, 1'b0)},
			'{exchange_item(8'h00, 1'b0), 1'b1, pins_low(CMD_SPEED, 1'b1, 1'b0)},
			'{exchange_item(8'h00, 1'b0), 1'b1, pins_low(CMD_SPEED, 1'b1, 1'b0)},
			'{exchange_item(8'hFF, 1'b0), 1'b1, pins_low(CMD_SPEED, 1'b1, 1'b0)},
			'{exchange_item(8'hFF, 1'b0), 1'b1, pins_low(CMD_SPEED, 1'b1, 1'b1)},
			// Just past the saturation point on both sides: 4096 and -4096.
			'{exchange_item(CMD_SPEED, 1'b0), 1'b0, dmspc_pkg::result_t'('0)},
			'{exchange_item(8'h10, 1'b0), 1'b0, dmspc_pkg::result_t'('0)},
			'{exchange_item(8'h00, 1'b0), 1'b0, dmspc_pkg::result_t'('0)},
			'{exchange_item(8'hF0, 1'b0), 1'b0, dmspc_pkg::result_t'('0)},
			'{exchange_item(8'h00, 1'b0), 1'b0, dmspc_pkg::result_t'('0)},
			// Exactly at the saturation point: 4095 and -4095.
			'{exchange_item(CMD_SPEED, 1'b0), 1'b0, dmspc_pkg::result_t'('0)},
			'{exchange_item(8'h0F, 1'b0), 1'b0, dmspc_pkg::result_t'('0)},
			'{exchange_item(8'hFF, 1'b0), 1'b0, dmspc_pkg::result_t'('0)},
			'{exchange_item(8'hF0, 1'b0), 1'b0, dmspc_pkg::result_t'('0)},
			'{exchange_item(8'h01, 1'b0), 1'b0, dmspc_pkg::result_t'('0)}
		};

		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

		// The sender waits here until the block has answered everything.
		drain_results();

		// Random part in phases. One phase sends back to back and then waits for a
		// full drain, which repeats the pause once.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			sender_quiet = (ph == 2);
			phase_end = counted_items + PHASE_ITEMS;
			while (counted_items < phase_end)
				send_random_event();
			if (ph == 2)
				drain_results();
		end

		// Wait for the last results, then keep watching the result side to catch any extra one.
		drain_results();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && pending_outputs.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/dmspc_pkg.sv
src/dual_motor_spi_pwm_controller.sv
dv/tb_dual_motor_spi_pwm_controller.sv
